// File: src/msgpack_stream_scanner_assert.svh
// ----------------------------------------------------------------------------
// msgpack_stream_scanner assertion macros
// Concurrent check macros shared by the stack and top-level scanner modules; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_STREAM_SCANNER_ASSERT_SVH
`define MSGPACK_STREAM_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS
// check a property on every rising clock edge outside reset
`define MSS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
// check that a condition implies a consequence in the same cycle
`define MSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`else
`define MSS_ASSERT(lbl, clk, rstn, prop)
`define MSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Request types, type and token codes, lead byte codes and state record
// shared by the MessagePack stream scanner modules.
// ----------------------------------------------------------------------------
package mss_pkg;

  // nesting levels held by the stack
  localparam int unsigned NEST_DEPTH = 16;

  localparam int unsigned CNT_W   = 17;
  localparam int unsigned DEPTH_W = $clog2(NEST_DEPTH + 1);
  localparam int unsigned LVL_W   = DEPTH_W;

  // scanner phases
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_EXT  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;
  localparam logic [1:0] PH_IGN  = 2'd3;

  // token kinds
  localparam logic [1:0] TK_LEAD = 2'd0;
  localparam logic [1:0] TK_EXT  = 2'd1;
  localparam logic [1:0] TK_PAY  = 2'd2;
  localparam logic [1:0] TK_IGN  = 2'd3;

  // value type codes
  localparam logic [3:0] T_POSFIX = 4'd0;
  localparam logic [3:0] T_NEGFIX = 4'd1;
  localparam logic [3:0] T_NIL    = 4'd2;
  localparam logic [3:0] T_FALSE  = 4'd3;
  localparam logic [3:0] T_TRUE   = 4'd4;
  localparam logic [3:0] T_UINT8  = 4'd5;
  localparam logic [3:0] T_UINT16 = 4'd6;
  localparam logic [3:0] T_UINT32 = 4'd7;
  localparam logic [3:0] T_INT8   = 4'd8;
  localparam logic [3:0] T_INT16  = 4'd9;
  localparam logic [3:0] T_INT32  = 4'd10;
  localparam logic [3:0] T_STR    = 4'd11;
  localparam logic [3:0] T_BIN    = 4'd12;
  localparam logic [3:0] T_MAP    = 4'd13;
  localparam logic [3:0] T_ARRAY  = 4'd14;
  localparam logic [3:0] T_BAD    = 4'd15;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNSUP = 2'd1;
  localparam logic [1:0] ERR_DEEP  = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  // lead bytes outside the fixed-format ranges
  localparam logic [7:0] LB_NIL    = 8'hC0;
  localparam logic [7:0] LB_FALSE  = 8'hC2;
  localparam logic [7:0] LB_TRUE   = 8'hC3;
  localparam logic [7:0] LB_BIN8   = 8'hC4;
  localparam logic [7:0] LB_BIN16  = 8'hC5;
  localparam logic [7:0] LB_BIN32  = 8'hC6;
  localparam logic [7:0] LB_UINT8  = 8'hCC;
  localparam logic [7:0] LB_UINT16 = 8'hCD;
  localparam logic [7:0] LB_UINT32 = 8'hCE;
  localparam logic [7:0] LB_INT8   = 8'hD0;
  localparam logic [7:0] LB_INT16  = 8'hD1;
  localparam logic [7:0] LB_INT32  = 8'hD2;
  localparam logic [7:0] LB_STR8   = 8'hD9;
  localparam logic [7:0] LB_STR16  = 8'hDA;
  localparam logic [7:0] LB_ARR16  = 8'hDC;
  localparam logic [7:0] LB_MAP16  = 8'hDE;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
  } mss_in_t;

  typedef struct packed {
    logic [1:0]         token_kind;
    logic [3:0]         type_code;
    logic               header_done;
    logic signed [31:0] int_value;
    logic [31:0]        length;
    logic [DEPTH_W-1:0] depth;
    logic               top_done;
    logic [1:0]         error_code;
  } mss_out_t;

  // scalar scanner state
  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  ptype;
    logic [2:0]  ext_left;
    logic [31:0] asm_val;
    logic [31:0] pay_left;
    logic [1:0]  err;
  } mss_state_t;

  // stack request from the decoder
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [CNT_W-1:0] count;
  } mss_stk_cmd_t;

endpackage

// File: src/mss_stack.sv
// ----------------------------------------------------------------------------
// mss_stack
// Open-element counters, one cell per nesting level, with a pop cascade
// resolved combinationally from per-level last-element flags.
// ----------------------------------------------------------------------------
`include "msgpack_stream_scanner_assert.svh"

module mss_stack
  import mss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             flush_i,
  input  mss_stk_cmd_t     cmd_i,
  output logic [LVL_W-1:0] level_o,
  output logic [LVL_W-1:0] pop_level_o
);

  logic [LVL_W-1:0]      level_q;
  logic [LVL_W-1:0]      level_d;
  logic [LVL_W-1:0]      lvl_eff;
  logic [LVL_W-1:0]      pop_lvl;
  logic [NEST_DEPTH-1:0] last_flag;
  logic [CNT_W-1:0]      count_q [NEST_DEPTH];

  // a new frame starts with an empty stack
  assign lvl_eff = flush_i ? '0 : level_q;

  // level left after a value closes: just above the highest open level
  // that still has more than one element to go
  always_comb begin
    pop_lvl = '0;
    for (int i = 0; i < NEST_DEPTH; i++) begin
      if ((LVL_W'(i) < lvl_eff) && !last_flag[i]) begin
        pop_lvl = LVL_W'(i + 1);
      end
    end
  end

  // per-level counter cells
  for (genvar g = 0; g < NEST_DEPTH; g++) begin : g_cell
    localparam logic [LVL_W-1:0] CELL_LVL = LVL_W'(g);
    localparam logic [LVL_W-1:0] CELL_TOP = LVL_W'(g + 1);

    assign last_flag[g] = (count_q[g] == CNT_W'(1));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cmd_i.push && (lvl_eff == CELL_LVL)) begin
          count_q[g] <= cmd_i.count;
        end else if (cmd_i.pop && (pop_lvl == CELL_TOP)) begin
          count_q[g] <= count_q[g] - CNT_W'(1);
        end
      end
    end
  end

  // level update
  always_comb begin
    if (cmd_i.push) begin
      level_d = lvl_eff + LVL_W'(1);
    end else if (cmd_i.pop) begin
      level_d = pop_lvl;
    end else begin
      level_d = lvl_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
    end
  end

  assign level_o     = lvl_eff;
  assign pop_level_o = pop_lvl;

  // checks
  `MSS_ASSERT(a_level_bound, clk_i, rst_ni, level_q <= LVL_W'(NEST_DEPTH))
  `MSS_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, en_i && cmd_i.push, lvl_eff < LVL_W'(NEST_DEPTH))

endmodule

// File: src/mss_decode.sv
// ----------------------------------------------------------------------------
// mss_decode
// Per-byte classification, header assembly, integer decode and next-state
// logic of the MessagePack stream scanner.
// ----------------------------------------------------------------------------
module mss_decode
  import mss_pkg::*;
(
  input  mss_in_t          item_i,
  input  mss_state_t       state_i,
  input  logic [LVL_W-1:0] level_i,
  input  logic [LVL_W-1:0] pop_level_i,
  output mss_state_t       state_o,
  output mss_stk_cmd_t     cmd_o,
  output mss_out_t         res_o
);

  mss_state_t       nxt;
  mss_out_t         res;
  logic [7:0]       b;
  logic             hc;
  logic [3:0]       ht;
  logic [31:0]      hv;
  logic             ext_go;
  logic [3:0]       ext_t;
  logic [2:0]       ext_n;
  logic             close;
  logic             open;
  logic             push;
  logic [CNT_W-1:0] elems;
  logic             go_err;
  logic [1:0]       err_code;
  logic [31:0]      asm_new;
  logic [31:0]      pay_new;
  logic [LVL_W-1:0] lvl_next;

  assign b = item_i.data_byte;

  always_comb begin
    res      = '0;
    nxt      = item_i.frame_start ? '0 : state_i;
    hc       = 1'b0;
    ht       = T_POSFIX;
    hv       = '0;
    ext_go   = 1'b0;
    ext_t    = T_POSFIX;
    ext_n    = '0;
    close    = 1'b0;
    open     = 1'b0;
    push     = 1'b0;
    elems    = '0;
    go_err   = 1'b0;
    err_code = ERR_NONE;
    asm_new  = {state_i.asm_val[23:0], b};
    pay_new  = state_i.pay_left - 32'd1;

    // byte classification by phase
    unique case (nxt.phase)
      PH_IGN: begin
        res.token_kind = TK_IGN;
        res.error_code = nxt.err;
      end
      PH_LEAD: begin
        res.token_kind = TK_LEAD;
        if (!b[7]) begin
          res.type_code = T_POSFIX;
          hc = 1'b1;
          ht = T_POSFIX;
          hv = {24'd0, b};
        end else if (b[7:5] == 3'b111) begin
          res.type_code = T_NEGFIX;
          hc = 1'b1;
          ht = T_NEGFIX;
          hv = {24'd0, b};
        end else if (b[7:4] == 4'h8) begin
          res.type_code = T_MAP;
          hc = 1'b1;
          ht = T_MAP;
          hv = {28'd0, b[3:0]};
        end else if (b[7:4] == 4'h9) begin
          res.type_code = T_ARRAY;
          hc = 1'b1;
          ht = T_ARRAY;
          hv = {28'd0, b[3:0]};
        end else if (b[7:5] == 3'b101) begin
          res.type_code = T_STR;
          hc = 1'b1;
          ht = T_STR;
          hv = {27'd0, b[4:0]};
        end else begin
          unique case (b)
            LB_NIL: begin
              res.type_code = T_NIL;
              hc = 1'b1;
              ht = T_NIL;
            end
            LB_FALSE: begin
              res.type_code = T_FALSE;
              hc = 1'b1;
              ht = T_FALSE;
            end
            LB_TRUE: begin
              res.type_code = T_TRUE;
              hc = 1'b1;
              ht = T_TRUE;
            end
            LB_BIN8:   begin ext_go = 1'b1; ext_t = T_BIN;    ext_n = 3'd1; end
            LB_BIN16:  begin ext_go = 1'b1; ext_t = T_BIN;    ext_n = 3'd2; end
            LB_BIN32:  begin ext_go = 1'b1; ext_t = T_BIN;    ext_n = 3'd4; end
            LB_UINT8:  begin ext_go = 1'b1; ext_t = T_UINT8;  ext_n = 3'd1; end
            LB_UINT16: begin ext_go = 1'b1; ext_t = T_UINT16; ext_n = 3'd2; end
            LB_UINT32: begin ext_go = 1'b1; ext_t = T_UINT32; ext_n = 3'd4; end
            LB_INT8:   begin ext_go = 1'b1; ext_t = T_INT8;   ext_n = 3'd1; end
            LB_INT16:  begin ext_go = 1'b1; ext_t = T_INT16;  ext_n = 3'd2; end
            LB_INT32:  begin ext_go = 1'b1; ext_t = T_INT32;  ext_n = 3'd4; end
            LB_STR8:   begin ext_go = 1'b1; ext_t = T_STR;    ext_n = 3'd1; end
            LB_STR16:  begin ext_go = 1'b1; ext_t = T_STR;    ext_n = 3'd2; end
            LB_ARR16:  begin ext_go = 1'b1; ext_t = T_ARRAY;  ext_n = 3'd2; end
            LB_MAP16:  begin ext_go = 1'b1; ext_t = T_MAP;    ext_n = 3'd2; end
            default: begin
              res.type_code = T_BAD;
              go_err   = 1'b1;
              err_code = ERR_UNSUP;
            end
          endcase
        end
        // header continues in extension bytes
        if (ext_go) begin
          res.type_code = ext_t;
          nxt.ptype     = ext_t;
          nxt.ext_left  = ext_n;
          nxt.asm_val   = '0;
          nxt.phase     = PH_EXT;
        end
      end
      PH_EXT: begin
        res.token_kind = TK_EXT;
        res.type_code  = nxt.ptype;
        nxt.asm_val    = asm_new;
        nxt.ext_left   = nxt.ext_left - 3'd1;
        if (nxt.ext_left == 3'd0) begin
          hc = 1'b1;
          ht = nxt.ptype;
          hv = asm_new;
        end
      end
      PH_PAY: begin
        res.token_kind = TK_PAY;
        res.type_code  = nxt.ptype;
        nxt.pay_left   = pay_new;
        res.length     = pay_new;
        if (pay_new == 32'd0) begin
          nxt.phase = PH_LEAD;
          close     = 1'b1;
        end
      end
      default: ;
    endcase

    // completed header
    if (hc) begin
      res.header_done = 1'b1;
      nxt.phase       = PH_LEAD;
      case (ht) inside
        T_NEGFIX: begin
          res.int_value = hv | 32'hFFFF_FF00;
          close = 1'b1;
        end
        T_INT8: begin
          res.int_value = {{24{hv[7]}}, hv[7:0]};
          close = 1'b1;
        end
        T_INT16: begin
          res.int_value = {{16{hv[15]}}, hv[15:0]};
          close = 1'b1;
        end
        T_POSFIX, T_UINT8, T_UINT16, T_UINT32, T_INT32: begin
          res.int_value = hv;
          close = 1'b1;
        end
        T_STR, T_BIN: begin
          res.length = hv;
          if (hv == 32'd0) begin
            close = 1'b1;
          end else begin
            nxt.pay_left = hv;
            nxt.phase    = PH_PAY;
          end
        end
        T_MAP: begin
          res.length = hv;
          elems = {hv[15:0], 1'b0};
          open  = 1'b1;
        end
        T_ARRAY: begin
          res.length = hv;
          elems = {1'b0, hv[15:0]};
          open  = 1'b1;
        end
        default: close = 1'b1;
      endcase
    end

    // container header: empty closes, full stack flags, else push
    if (open) begin
      if (elems == '0) begin
        close = 1'b1;
      end else if (level_i >= LVL_W'(NEST_DEPTH)) begin
        go_err   = 1'b1;
        err_code = ERR_DEEP;
      end else begin
        push = 1'b1;
      end
    end

    if (go_err) begin
      res.error_code = err_code;
      nxt.err        = err_code;
      nxt.phase      = PH_IGN;
    end

    // level after this byte
    if (push) begin
      lvl_next = level_i + LVL_W'(1);
    end else if (close) begin
      lvl_next = pop_level_i;
    end else begin
      lvl_next = level_i;
    end
    res.top_done = close && (pop_level_i == '0);

    // frame ends with a value still open
    if (item_i.frame_end && (res.token_kind != TK_IGN) && (nxt.phase != PH_IGN) &&
        ((nxt.phase != PH_LEAD) || (lvl_next != '0))) begin
      res.error_code = ERR_TRUNC;
      nxt.err        = ERR_TRUNC;
      nxt.phase      = PH_IGN;
    end

    res.depth = DEPTH_W'(lvl_next);
  end

  assign state_o    = nxt;
  assign res_o      = res;
  assign cmd_o.push  = push;
  assign cmd_o.pop   = close;
  assign cmd_o.count = elems;

endmodule

// File: src/msgpack_stream_scanner.sv
// ----------------------------------------------------------------------------
// msgpack_stream_scanner
// Byte-serial MessagePack subset scanner with nesting stack and error latch.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while the output side keeps taking
// results, and gives one result per byte. A byte is accepted into an input
// register, decoded combinationally against the scanner state and the
// nesting stack, and lands in a result register once that register is
// free, so the sustained rate is one byte every cycle while the output side
// keeps taking results. The stack holds NEST_DEPTH counter cells in
// flip-flops; when a value closes, every emptied level is popped in the
// same cycle using per-level last-element flags. No clearing pass follows
// reset: frame_start empties the stack and clears the error latch, and
// stack cells are always written before they are read.
`include "msgpack_stream_scanner_assert.svh"

module msgpack_stream_scanner
  import mss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mss_out_t out_data_o
);

  logic             in_valid_q;
  mss_in_t          in_q;
  logic             out_valid_q;
  mss_out_t         out_q;
  mss_out_t         res_d;
  mss_state_t       st_q;
  mss_state_t       st_d;
  mss_stk_cmd_t     stk_cmd;
  logic [LVL_W-1:0] stk_level;
  logic [LVL_W-1:0] stk_pop_level;
  logic             out_free;
  logic             fire;

  // request flow: result register free or draining this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // byte decode
  mss_decode u_decode (
    .item_i     (in_q),
    .state_i    (st_q),
    .level_i    (stk_level),
    .pop_level_i(stk_pop_level),
    .state_o    (st_d),
    .cmd_o      (stk_cmd),
    .res_o      (res_d)
  );

  // nesting stack
  mss_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .flush_i    (in_q.frame_start),
    .cmd_i      (stk_cmd),
    .level_o    (stk_level),
    .pop_level_o(stk_pop_level)
  );

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `MSS_ASSERT_IMPL(a_err_ignores, clk_i, rst_ni, st_q.err != ERR_NONE, st_q.phase == PH_IGN)
  `MSS_ASSERT_IMPL(a_ext_pending, clk_i, rst_ni, st_q.phase == PH_EXT, st_q.ext_left != 3'd0)
  `MSS_ASSERT_IMPL(a_pay_pending, clk_i, rst_ni, st_q.phase == PH_PAY, st_q.pay_left != 32'd0)
  `MSS_ASSERT_IMPL(a_hdr_kind, clk_i, rst_ni, out_valid_q && out_q.header_done, out_q.token_kind == TK_LEAD || out_q.token_kind == TK_EXT)
  `MSS_ASSERT_IMPL(a_out_from_fire, clk_i, rst_ni, $rose(out_valid_q), $past(fire))

endmodule

// File: verif/mss_tb_pkg.sv
// ----------------------------------------------------------------------------
// mss_tb_pkg
// Scoreboard for the MessagePack stream scanner: keeps a copy of the scanner
// state, works out the expected token for each accepted request and compares
// the tokens that come back, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mss_tb_pkg;
  import mss_pkg::*;

  localparam int unsigned NEST_LEVELS = NEST_DEPTH;
  localparam int unsigned IDX_W       = $clog2(NEST_LEVELS);
  localparam int unsigned MAX_PRINTS  = 40;

  class mss_scoreboard;
    mss_out_t    token_q[$];
    int unsigned mismatches;
    int unsigned scanned;
    int unsigned results;

    // mirrored scanner state
    logic [1:0]         phase;
    logic [3:0]         ptype;
    logic [2:0]         ext_left;
    logic [31:0]        asm_val;
    logic [31:0]        pay_left;
    logic [CNT_W-1:0]   open_cnt [NEST_LEVELS];
    logic [DEPTH_W-1:0] level;
    logic [1:0]         err_latch;

    // token being built for the current byte
    mss_out_t res;

    function new();
      mismatches = 0;
      scanned    = 0;
      results    = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PH_LEAD;
      ptype     = T_POSFIX;
      ext_left  = '0;
      asm_val   = '0;
      pay_left  = '0;
      level     = '0;
      err_latch = ERR_NONE;
      foreach (open_cnt[i]) open_cnt[i] = '0;
    endfunction

    // one value finished: count it off, popping every level that empties
    function logic close_value();
      while (level > 0) begin
        open_cnt[IDX_W'(level - 1'b1)] = open_cnt[IDX_W'(level - 1'b1)] - 1'b1;
        if (open_cnt[IDX_W'(level - 1'b1)] != '0) return 1'b0;
        level = level - 1'b1;
      end
      return 1'b1;
    endfunction

    function void go_error(logic [1:0] code);
      res.error_code = code;
      err_latch      = code;
      phase          = PH_IGN;
    endfunction

    function void open_container(logic [CNT_W-1:0] elems);
      if (elems == '0) begin
        res.top_done = close_value();
      end else if (level >= NEST_LEVELS) begin
        go_error(ERR_DEEP);
      end else begin
        open_cnt[IDX_W'(level)] = elems;
        level                   = level + 1'b1;
      end
    endfunction

    function void finish_header(logic [3:0] t, logic [31:0] v);
      res.type_code   = t;
      res.header_done = 1'b1;
      phase           = PH_LEAD;
      case (t)
        T_STR, T_BIN: begin
          res.length = v;
          if (v == '0) begin
            res.top_done = close_value();
          end else begin
            pay_left = v;
            phase    = PH_PAY;
          end
        end
        T_MAP: begin
          res.length = v;
          open_container({v[15:0], 1'b0});
        end
        T_ARRAY: begin
          res.length = v;
          open_container({1'b0, v[15:0]});
        end
        default: begin
          // scalars: integers carry a value, nil and booleans carry none
          case (t)
            T_NEGFIX, T_INT8: res.int_value = {{24{v[7]}}, v[7:0]};
            T_INT16:          res.int_value = {{16{v[15]}}, v[15:0]};
            T_POSFIX, T_UINT8, T_UINT16, T_UINT32, T_INT32: res.int_value = v;
            default:          res.int_value = '0;
          endcase
          res.top_done = close_value();
        end
      endcase
    endfunction

    function void start_ext(logic [3:0] t, logic [2:0] n);
      res.type_code = t;
      ptype         = t;
      ext_left      = n;
      asm_val       = '0;
      phase         = PH_EXT;
    endfunction

    function void scan_lead(logic [7:0] b);
      res.token_kind = TK_LEAD;
      if (!b[7]) begin
        finish_header(T_POSFIX, {24'd0, b});
      end else if (b[7:5] == 3'b111) begin
        finish_header(T_NEGFIX, {24'd0, b});
      end else if (b[7:4] == 4'h8) begin
        finish_header(T_MAP, {28'd0, b[3:0]});
      end else if (b[7:4] == 4'h9) begin
        finish_header(T_ARRAY, {28'd0, b[3:0]});
      end else if (b[7:5] == 3'b101) begin
        finish_header(T_STR, {27'd0, b[4:0]});
      end else begin
        case (b)
          LB_NIL:    finish_header(T_NIL, '0);
          LB_FALSE:  finish_header(T_FALSE, '0);
          LB_TRUE:   finish_header(T_TRUE, '0);
          LB_BIN8:   start_ext(T_BIN, 3'd1);
          LB_BIN16:  start_ext(T_BIN, 3'd2);
          LB_BIN32:  start_ext(T_BIN, 3'd4);
          LB_UINT8:  start_ext(T_UINT8, 3'd1);
          LB_UINT16: start_ext(T_UINT16, 3'd2);
          LB_UINT32: start_ext(T_UINT32, 3'd4);
          LB_INT8:   start_ext(T_INT8, 3'd1);
          LB_INT16:  start_ext(T_INT16, 3'd2);
          LB_INT32:  start_ext(T_INT32, 3'd4);
          LB_STR8:   start_ext(T_STR, 3'd1);
          LB_STR16:  start_ext(T_STR, 3'd2);
          LB_ARR16:  start_ext(T_ARRAY, 3'd2);
          LB_MAP16:  start_ext(T_MAP, 3'd2);
          default: begin
            res.type_code = T_BAD;
            go_error(ERR_UNSUP);
          end
        endcase
      end
    endfunction

    // accepted request: advance the mirrored state and queue the token
    function void note_request(mss_in_t req);
      res = '0;
      if (req.frame_start) clear_state();
      case (phase)
        PH_IGN: begin
          res.token_kind = TK_IGN;
          res.error_code = err_latch;
        end
        PH_LEAD: scan_lead(req.data_byte);
        PH_EXT: begin
          res.token_kind = TK_EXT;
          res.type_code  = ptype;
          asm_val        = {asm_val[23:0], req.data_byte};
          ext_left       = ext_left - 3'd1;
          if (ext_left == '0) finish_header(ptype, asm_val);
        end
        default: begin
          res.token_kind = TK_PAY;
          res.type_code  = ptype;
          pay_left       = pay_left - 1'b1;
          res.length     = pay_left;
          if (pay_left == '0) begin
            phase        = PH_LEAD;
            res.top_done = close_value();
          end
        end
      endcase
      // frame ends with a value still open
      if (req.frame_end && res.token_kind != TK_IGN && phase != PH_IGN &&
          (phase != PH_LEAD || level != '0))
        go_error(ERR_TRUNC);
      res.depth = level;
      scanned++;
      token_q.push_back(res);
    endfunction

    function int unsigned pending_tokens();
      return token_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("[%0t] mismatch on result %0d: %s", $time, results, msg);
    endtask

    task compare(string field, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
        report($sformatf("%s got %0h want %0h", field, got_v, want_v));
    endtask

    // returned token against the oldest expectation
    task check_token(mss_out_t got);
      mss_out_t want;
      results++;
      if (token_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = token_q.pop_front();
      compare("token_kind",  32'(got.token_kind),  32'(want.token_kind));
      compare("type_code",   32'(got.type_code),   32'(want.type_code));
      compare("header_done", 32'(got.header_done), 32'(want.header_done));
      compare("int_value",   got.int_value,        want.int_value);
      compare("length",      got.length,           want.length);
      compare("depth",       32'(got.depth),       32'(want.depth));
      compare("top_done",    32'(got.top_done),    32'(want.top_done));
      compare("error_code",  32'(got.error_code),  32'(want.error_code));
    endtask
  endclass

endpackage

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the MessagePack stream scanner with framed byte streams: a short
// directed set of edge values, then random well-formed frames, deep nesting,
// broken frames and raw noise, under bursty input and a stalling output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mss_pkg::*;
  import mss_tb_pkg::*;

  localparam int unsigned SCAN_TARGET  = 650;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 80;

  // lead byte prefixes not named in the package
  localparam logic [7:0] LB_FIXMAP = 8'h80;
  localparam logic [7:0] LB_FIXARR = 8'h90;
  localparam logic [7:0] LB_FIXSTR = 8'hA0;
  localparam logic [7:0] LB_NEGFIX = 8'hE0;
  localparam logic [7:0] LB_NEVER  = 8'hC1;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  mss_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  mss_out_t out_data_o;

  mss_scoreboard sb;
  logic [7:0]    frame_bytes[$];
  int unsigned   burst_left;

  msgpack_stream_scanner u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // one request, sent in bursts with random gaps between them
  task automatic send_byte(input mss_in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(req);
    burst_left--;
  endtask

  // whole frame: start flag on the first byte, end flag on the last
  task automatic send_frame();
    mss_in_t req;
    foreach (frame_bytes[i]) begin
      req.data_byte   = frame_bytes[i];
      req.frame_start = (i == 0);
      req.frame_end   = (i == frame_bytes.size() - 1);
      send_byte(req);
    end
  endtask

  function automatic void emit_random(int unsigned n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endfunction

  // mostly short strings, now and then the longest fixstr
  function automatic int unsigned short_len();
    return ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(0, 5);
  endfunction

  // one well-formed value with random content, nesting kept shallow
  function automatic void emit_value(int unsigned lvl);
    int unsigned n;
    n = 0;
    case ($urandom_range(0, 15))
      0: frame_bytes.push_back(8'($urandom_range(0, 127)));
      1: frame_bytes.push_back(8'(LB_NEGFIX | $urandom_range(0, 31)));
      2: begin
        case ($urandom_range(0, 2))
          0:       frame_bytes.push_back(LB_NIL);
          1:       frame_bytes.push_back(LB_FALSE);
          default: frame_bytes.push_back(LB_TRUE);
        endcase
      end
      3: begin frame_bytes.push_back(LB_UINT8);  emit_random(1); end
      4: begin frame_bytes.push_back(LB_UINT16); emit_random(2); end
      5: begin frame_bytes.push_back(LB_UINT32); emit_random(4); end
      6: begin frame_bytes.push_back(LB_INT8);   emit_random(1); end
      7: begin frame_bytes.push_back(LB_INT16);  emit_random(2); end
      8: begin frame_bytes.push_back(LB_INT32);  emit_random(4); end
      9: begin
        n = short_len();
        frame_bytes.push_back(8'(LB_FIXSTR | n));
        emit_random(n);
      end
      10: begin
        n = short_len();
        frame_bytes.push_back(LB_STR8);
        frame_bytes.push_back(8'(n));
        emit_random(n);
      end
      11: begin
        n = short_len();
        frame_bytes.push_back(LB_STR16);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'(n));
        emit_random(n);
      end
      12: begin
        n = short_len();
        case ($urandom_range(0, 2))
          0: frame_bytes.push_back(LB_BIN8);
          1: begin
            frame_bytes.push_back(LB_BIN16);
            frame_bytes.push_back(8'h00);
          end
          default: begin
            frame_bytes.push_back(LB_BIN32);
            repeat (3) frame_bytes.push_back(8'h00);
          end
        endcase
        frame_bytes.push_back(8'(n));
        emit_random(n);
      end
      13: begin
        n = (lvl < 3) ? $urandom_range(0, 3) : 0;
        frame_bytes.push_back(8'(LB_FIXMAP | n));
        repeat (2 * n) emit_value(lvl + 1);
      end
      14: begin
        n = (lvl < 3) ? $urandom_range(0, 4) : 0;
        frame_bytes.push_back(8'(LB_FIXARR | n));
        repeat (n) emit_value(lvl + 1);
      end
      default: begin
        n = (lvl < 3) ? $urandom_range(0, 3) : 0;
        if ($urandom_range(0, 1) == 0) begin
          frame_bytes.push_back(LB_MAP16);
          frame_bytes.push_back(8'h00);
          frame_bytes.push_back(8'(n));
          repeat (2 * n) emit_value(lvl + 1);
        end else begin
          frame_bytes.push_back(LB_ARR16);
          frame_bytes.push_back(8'h00);
          frame_bytes.push_back(8'(n));
          repeat (n) emit_value(lvl + 1);
        end
      end
    endcase
  endfunction

  // edge values, empty containers and the unsupported-byte and truncation error paths
  task automatic run_directed();
    frame_bytes = '{8'h00};                                   send_frame();
    frame_bytes = '{8'h7F};                                   send_frame();
    frame_bytes = '{LB_NEGFIX};                               send_frame();
    frame_bytes = '{8'hFF};                                   send_frame();
    frame_bytes = '{LB_UINT32, 8'hFF, 8'hFF, 8'hFF, 8'hFF};   send_frame();
    frame_bytes = '{LB_INT32, 8'h80, 8'h00, 8'h00, 8'h00};    send_frame();
    frame_bytes = '{LB_FIXMAP};                               send_frame();
    frame_bytes = '{LB_FIXSTR};                               send_frame();
    frame_bytes = '{LB_FIXARR | 8'h01, LB_NIL};               send_frame();
    // unsupported lead byte, then an ignored byte carrying the end flag
    frame_bytes = '{LB_NEVER, 8'h00};                         send_frame();
    // map left open at the end of the frame
    frame_bytes = '{LB_MAP16, 8'h00, 8'h01};                  send_frame();
  endtask

  task automatic run_random();
    int unsigned pick;
    int unsigned cut;
    mss_in_t     req;
    while (sb.scanned < SCAN_TARGET) begin
      pick = $urandom_range(0, 19);
      frame_bytes.delete();
      if (pick < 14) begin
        // well-formed frame of one to three top-level values
        repeat ($urandom_range(1, 3)) emit_value(0);
        send_frame();
      end else if (pick < 16) begin
        // nesting around the stack limit
        repeat ($urandom_range(14, 18)) begin
          if ($urandom_range(0, 1) == 0) begin
            frame_bytes.push_back(LB_FIXARR | 8'h01);
          end else begin
            frame_bytes.push_back(LB_ARR16);
            frame_bytes.push_back(8'h00);
            frame_bytes.push_back(8'h01);
          end
        end
        emit_value(3);
        send_frame();
      end else if (pick < 18) begin
        // broken frame: cut short or one byte corrupted
        emit_value(0);
        emit_value(0);
        if ($urandom_range(0, 1) == 0) begin
          cut = $urandom_range(1, frame_bytes.size());
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end else begin
          frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
        end
        send_frame();
      end else begin
        // raw noise with random frame flags
        repeat ($urandom_range(1, 8)) begin
          req.data_byte   = 8'($urandom);
          req.frame_start = ($urandom_range(0, 3) == 0);
          req.frame_end   = 1'($urandom_range(0, 1));
          send_byte(req);
        end
      end
    end
  endtask

  // output side stalls in changing modes, with one long hold-off
  initial begin : receiver
    int unsigned cyc;
    int unsigned hold;
    int unsigned mode;
    cyc         = 0;
    hold        = 0;
    mode        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc == HOLD_AT) hold = HOLD_CYCLES;
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= (cyc % 3 == 0);
          default: out_stall_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // returned tokens
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_token(out_data_o);
  end

  // main sequence
  initial begin
    sb         = new();
    burst_left = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (sb.pending_tokens() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
